// ----- src/etmr_pkg.sv -----
`default_nettype none

package etmr_pkg;

  // Sample width taken from the echo field; SumW, CmpW and DivCntW follow from it.
  localparam int SampleBits = 16;
  localparam int RegW       = 16;
  localparam int SumW       = SampleBits + 3;
  localparam int CmpW       = (SampleBits > RegW) ? SampleBits : RegW;
  localparam int CountW     = 3;
  localparam int DivCntW    = $clog2(SampleBits);

  localparam logic [CountW-1:0] BatchLen = CountW'(6);

  localparam logic [RegW-1:0] SpreadLimitRst  = RegW'(50);
  localparam logic [RegW-1:0] TickDivisorRst  = RegW'(58);
  localparam logic [RegW-1:0] SafeDistanceRst = RegW'(20);
  localparam logic [RegW-1:0] NearFloorRst    = RegW'(5);
  localparam logic [RegW-1:0] RegMax          = '1;

  localparam logic [1:0] RegSpreadLimit  = 2'd0;
  localparam logic [1:0] RegTickDivisor  = 2'd1;
  localparam logic [1:0] RegSafeDistance = 2'd2;
  localparam logic [1:0] RegNearFloor    = 2'd3;

  localparam logic [1:0] ZoneNone  = 2'd0;
  localparam logic [1:0] ZoneSafe  = 2'd1;
  localparam logic [1:0] ZoneClose = 2'd2;
  localparam logic [1:0] ZoneFloor = 2'd3;

  typedef struct packed {
    logic                  complete;
    logic                  spread_ok;
    logic [SampleBits-1:0] avg;
  } batch_t;

endpackage

`default_nettype wire

// ----- src/etmr_accum.sv -----
`default_nettype none

module etmr_accum import etmr_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  sample_valid_i,
  input  wire logic [SampleBits-1:0] sample_i,
  input  wire logic                  clear_i,
  input  wire logic [RegW-1:0]       spread_limit_i,
  output batch_t                     batch_o
);

  logic [CountW-1:0]     count_q, count_d;
  logic [SumW-1:0]       sum_q, sum_d;
  logic [SampleBits-1:0] max_q, max_d;
  logic [SampleBits-1:0] min_q, min_d;
  logic                  first_q, first_d;
  logic [SumW-1:0]       trimmed;
  logic [SampleBits-1:0] spread;

  always_comb begin
    count_d = count_q;
    sum_d   = sum_q;
    max_d   = max_q;
    min_d   = min_q;
    first_d = first_q;
    if (clear_i || (sample_valid_i && (sample_i == '0))) begin
      count_d = '0;
      sum_d   = '0;
      max_d   = '0;
      min_d   = '0;
      first_d = 1'b0;
    end else if (sample_valid_i) begin
      if (!first_q) begin
        first_d = 1'b1;
        max_d   = sample_i;
        min_d   = sample_i;
      end else if (sample_i > max_q) begin
        max_d = sample_i;
      end else if (sample_i < min_q) begin
        min_d = sample_i;
      end
      sum_d   = sum_q + SumW'(sample_i);
      count_d = count_q + CountW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      sum_q   <= '0;
      max_q   <= '0;
      min_q   <= '0;
      first_q <= 1'b0;
    end else begin
      count_q <= count_d;
      sum_q   <= sum_d;
      max_q   <= max_d;
      min_q   <= min_d;
      first_q <= first_d;
    end
  end

  // Drop the extremes; the four middle samples fit back in SampleBits after the shift.
  assign trimmed = sum_q - SumW'(max_q) - SumW'(min_q);
  assign spread  = max_q - min_q;

  assign batch_o.complete  = (count_q == BatchLen);
  assign batch_o.spread_ok = (CmpW'(spread) <= CmpW'(spread_limit_i));
  assign batch_o.avg       = trimmed[SampleBits+1:2];

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= BatchLen) else $error("batch count past batch length");
  a_min_le_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    first_q |-> (min_q <= max_q)) else $error("running min above running max");
  a_empty_batch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !first_q |-> (count_q == '0) && (sum_q == '0)) else $error("stale batch state");
`endif

endmodule

`default_nettype wire

// ----- src/etmr_div.sv -----
`default_nettype none

module etmr_div import etmr_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [SampleBits-1:0] dividend_i,
  input  wire logic [RegW-1:0]       divisor_i,
  output logic                       done_o,
  output logic [SampleBits-1:0]      quotient_o
);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [DivCntW-1:0]    cnt_q, cnt_d;
  logic [RegW-1:0]       rem_q, rem_d;
  logic [SampleBits-1:0] quo_q, quo_d;
  logic [RegW-1:0]       div_q;
  logic [RegW:0]         rem_shift;
  logic [RegW+1:0]       diff;
  logic                  take;

  // One quotient bit per cycle; dividend bits shift out of quo_q as quotient bits shift in.
  assign rem_shift = {rem_q, quo_q[SampleBits-1]};
  assign diff      = {1'b0, rem_shift} - {2'b00, div_q};
  assign take      = !diff[RegW+1];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = take ? diff[RegW-1:0] : rem_shift[RegW-1:0];
      quo_d = {quo_q[SampleBits-2:0], take};
      cnt_d = cnt_q + DivCntW'(1);
      if (cnt_q == DivCntW'(SampleBits - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      div_q <= divisor_i;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

`ifndef ASSERT_OFF
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("divider started while busy");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("divider done while busy");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("divider done held");
`endif

endmodule

`default_nettype wire

// ----- src/echo_trimmed_mean_ranger.sv -----
// Channel   Dir  Payload
// s_axis    in   tdata[15:0] echo_ticks
// m_axis    out  tdata[15:0] distance, [17:16] zone; tuser[0] reading_valid, [1] batch_rejected
// cfg       in   cfg_idx_i 0 spread_limit, 1 tick_divisor, 2 safe_distance, 3 near_floor
//
// An item that does not complete a batch goes from accept through StCheck and StEmit to the output register.
// The sixth item of a batch that passes the spread check also passes through StDiv, where the
// one-bit-per-cycle restoring divider forms the distance.
// s_axis_tready is high only while the sequencer is idle; the output register lets the next
// item in while a result waits. Reset restores register defaults and clears the batch.
`default_nettype none

module echo_trimmed_mean_ranger import etmr_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            s_axis_tvalid,
  output logic                 s_axis_tready,
  input  wire logic [15:0]     s_axis_tdata,   // [15:0] echo_ticks
  output logic                 m_axis_tvalid,
  input  wire logic            m_axis_tready,
  output logic [23:0]          m_axis_tdata,   // [15:0] distance, [17:16] zone, rest zero
  output logic [1:0]           m_axis_tuser,   // [0] reading_valid, [1] batch_rejected
  input  wire logic            cfg_we_i,
  input  wire logic [1:0]      cfg_idx_i,
  input  wire logic [RegW-1:0] cfg_wdata_i
);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StCheck = 2'd1;
  localparam logic [1:0] StDiv   = 2'd2;
  localparam logic [1:0] StEmit  = 2'd3;

  logic [1:0]            state_q, state_d;
  logic [RegW-1:0]       spread_limit_q, tick_divisor_q, safe_distance_q, near_floor_q;
  logic                  res_valid_q, res_valid_d;
  logic                  res_rej_q, res_rej_d;
  logic [RegW-1:0]       res_dist_q, res_dist_d;
  logic [1:0]            res_zone_q, res_zone_d;
  logic                  out_valid_q;
  logic [23:0]           out_data_q;
  logic [1:0]            out_user_q;
  logic                  in_accept;
  logic                  out_free;
  logic                  batch_clear;
  logic                  div_start;
  logic                  div_done;
  logic [SampleBits-1:0] quotient;
  logic [RegW-1:0]       distance;
  batch_t                batch;

  assign s_axis_tready = (state_q == StIdle);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  etmr_accum u_accum (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .sample_valid_i (in_accept),
    .sample_i       (SampleBits'(s_axis_tdata)),
    .clear_i        (batch_clear),
    .spread_limit_i (spread_limit_q),
    .batch_o        (batch)
  );

  etmr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (batch.avg),
    .divisor_i  (tick_divisor_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // Saturate quotients that outgrow the distance field.
  always_comb begin
    if ((SampleBits > RegW) && (CmpW'(quotient) > CmpW'(RegMax))) begin
      distance = RegMax;
    end else begin
      distance = RegW'(quotient);
    end
  end

  assign batch_clear = (state_q == StCheck) && batch.complete;
  assign div_start   = batch_clear && batch.spread_ok;

  always_comb begin
    state_d     = state_q;
    res_valid_d = res_valid_q;
    res_rej_d   = res_rej_q;
    res_dist_d  = res_dist_q;
    res_zone_d  = res_zone_q;
    unique case (state_q)
      StIdle: begin
        if (in_accept) begin
          state_d = StCheck;
        end
      end
      StCheck: begin
        res_valid_d = 1'b0;
        res_rej_d   = batch.complete && !batch.spread_ok;
        res_dist_d  = '0;
        res_zone_d  = ZoneNone;
        state_d     = div_start ? StDiv : StEmit;
      end
      StDiv: begin
        if (div_done) begin
          res_valid_d = 1'b1;
          res_dist_d  = distance;
          priority if (distance >= safe_distance_q) begin
            res_zone_d = ZoneSafe;
          end else if (distance >= near_floor_q) begin
            res_zone_d = ZoneClose;
          end else begin
            res_zone_d = ZoneFloor;
          end
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= StIdle;
      out_valid_q     <= 1'b0;
      spread_limit_q  <= SpreadLimitRst;
      tick_divisor_q  <= TickDivisorRst;
      safe_distance_q <= SafeDistanceRst;
      near_floor_q    <= NearFloorRst;
    end else begin
      state_q <= state_d;
      if ((state_q == StEmit) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          RegSpreadLimit:  spread_limit_q  <= cfg_wdata_i;
          RegTickDivisor:  tick_divisor_q  <= cfg_wdata_i;
          RegSafeDistance: safe_distance_q <= cfg_wdata_i;
          RegNearFloor:    near_floor_q    <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_valid_q <= res_valid_d;
    res_rej_q   <= res_rej_d;
    res_dist_q  <= res_dist_d;
    res_zone_q  <= res_zone_d;
    if ((state_q == StEmit) && out_free) begin
      out_data_q <= {6'b0, res_zone_q, res_dist_q};
      out_user_q <= {res_rej_q, res_valid_q};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

`ifndef ASSERT_OFF
  a_accept_to_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q == StCheck)) else $error("accepted item not checked");
  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("result both valid and rejected");
  a_zone_with_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((m_axis_tdata[17:16] != ZoneNone) == m_axis_tuser[0]))
    else $error("zone disagrees with reading_valid");
`endif

endmodule

`default_nettype wire

// ----- tb/sv/tb_echo_trimmed_mean_ranger.sv -----
`timescale 1ns / 1ps

module tb_echo_trimmed_mean_ranger;
  import etmr_pkg::*;

  localparam int StallLimit  = 2000;
  localparam int SettleTicks = 24;
  localparam int RandomItems = 590;

  typedef struct packed {
    logic            valid;
    logic            rejected;
    logic [RegW-1:0] distance;
    logic [1:0]      zone;
  } reading_t;

  logic            clk_i;
  logic            rst_ni;
  logic            s_axis_tvalid;
  logic            s_axis_tready;
  logic [15:0]     s_axis_tdata;
  logic            m_axis_tvalid;
  logic            m_axis_tready;
  logic [23:0]     m_axis_tdata;
  logic [1:0]      m_axis_tuser;
  logic            cfg_we_i;
  logic [1:0]      cfg_idx_i;
  logic [RegW-1:0] cfg_wdata_i;

  echo_trimmed_mean_ranger dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // Shadow copy of the filter: registers and batch accumulators.
  logic [RegW-1:0]       lim_cfg, div_cfg, safe_cfg, floor_cfg;
  logic [CountW-1:0]     batch_fill;
  logic [SumW-1:0]       tick_sum;
  logic [SampleBits-1:0] peak_hi, peak_lo;
  logic                  primed;

  reading_t pending_readings[$];
  int       mismatches;
  int       items_sent;
  int       idle_cycles;
  int       rx_wait;
  bit       tx_steady;
  bit       rx_steady;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic reading_t predict_reading(logic [15:0] ticks);
    reading_t              r;
    logic [SampleBits-1:0] s;
    logic [SumW-1:0]       trimmed;
    logic [SampleBits-1:0] avg;
    logic [RegW-1:0]       q;
    r = '0;
    s = ticks[SampleBits-1:0];
    if (s == '0) begin
      batch_fill = '0;
      tick_sum   = '0;
      peak_hi    = '0;
      peak_lo    = '0;
      primed     = 1'b0;
    end else begin
      if (!primed) begin
        primed  = 1'b1;
        peak_hi = s;
        peak_lo = s;
      end else if (s > peak_hi) begin
        peak_hi = s;
      end else if (s < peak_lo) begin
        peak_lo = s;
      end
      tick_sum   = tick_sum + SumW'(s);
      batch_fill = batch_fill + 1'b1;
      if (batch_fill >= BatchLen) begin
        trimmed = tick_sum - SumW'(peak_hi) - SumW'(peak_lo);
        avg     = trimmed[SampleBits+1:2];
        if (peak_hi - peak_lo <= lim_cfg) begin
          q = (div_cfg == '0) ? RegMax : RegW'(avg / div_cfg);
          r.valid    = 1'b1;
          r.distance = q;
          if (q >= safe_cfg) r.zone = ZoneSafe;
          else if (q >= floor_cfg) r.zone = ZoneClose;
          else r.zone = ZoneFloor;
        end else begin
          r.rejected = 1'b1;
        end
        batch_fill = '0;
        tick_sum   = '0;
        peak_hi    = '0;
        peak_lo    = '0;
        primed     = 1'b0;
      end
    end
    return r;
  endfunction

  // Check every result that leaves the block against the oldest prediction.
  always @(posedge clk_i) begin
    reading_t want, got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.valid    = m_axis_tuser[0];
      got.rejected = m_axis_tuser[1];
      got.distance = m_axis_tdata[15:0];
      got.zone     = m_axis_tdata[17:16];
      if (pending_readings.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected reading: valid=%0d rej=%0d dist=%0d zone=%0d",
                   got.valid, got.rejected, got.distance, got.zone);
      end else begin
        want = pending_readings.pop_front();
        if (got.valid !== want.valid || got.rejected !== want.rejected ||
            got.distance !== want.distance || got.zone !== want.zone ||
            m_axis_tdata[23:18] !== 6'd0) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"reading mismatch: expected valid=%0d rej=%0d dist=%0d zone=%0d, ",
                      "got valid=%0d rej=%0d dist=%0d zone=%0d pad=%h"},
                     want.valid, want.rejected, want.distance, want.zone,
                     got.valid, got.rejected, got.distance, got.zone,
                     m_axis_tdata[23:18]);
        end
      end
      rx_wait = rx_steady ? 0 : $urandom_range(0, 9);
    end
  end

  // Hold tready low for the drawn number of cycles after each result.
  always @(negedge clk_i) begin
    if (rx_wait > 0) begin
      rx_wait--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("echo_trimmed_mean_ranger regression: fail");
        $finish;
      end
    end
  end

  task automatic send_echo(input logic [15:0] ticks);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      @(negedge clk_i) s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ticks;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_readings.push_back(predict_reading(ticks));
    items_sent++;
  endtask

  // Six nonzero echoes spread over [base, base + width].
  task automatic send_batch(input int unsigned base, input int unsigned width);
    int unsigned v;
    repeat (6) begin
      v = base + $urandom_range(0, width);
      if (v > 65535) v = 65535;
      if (v == 0) v = 1;
      send_echo(16'(v));
    end
  endtask

  task automatic drain_results();
    @(negedge clk_i) s_axis_tvalid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk_i);
    repeat (SettleTicks) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [RegW-1:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(negedge clk_i) cfg_we_i <= 1'b0;
    case (idx)
      RegSpreadLimit:  lim_cfg   = value;
      RegTickDivisor:  div_cfg   = value;
      RegSafeDistance: safe_cfg  = value;
      RegNearFloor:    floor_cfg = value;
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [RegW-1:0] lim, input logic [RegW-1:0] dv,
                                input logic [RegW-1:0] safe, input logic [RegW-1:0] flr);
    drain_results();
    write_reg(RegSpreadLimit, lim);
    write_reg(RegTickDivisor, dv);
    write_reg(RegSafeDistance, safe);
    write_reg(RegNearFloor, flr);
  endtask

  // Reset values: accepted, cleared, rejected and full-scale batches.
  task automatic test_reset_defaults();
    send_echo(16'd0);
    send_echo(16'd1160);
    send_echo(16'd1170);
    send_echo(16'd1150);
    send_echo(16'd1165);
    send_echo(16'd1155);
    send_echo(16'd1160);
    // a missing echo drops the partial batch
    send_echo(16'd1000);
    send_echo(16'd0);
    send_echo(16'd100);
    send_echo(16'd200);
    send_echo(16'd300);
    send_echo(16'd400);
    send_echo(16'd500);
    send_echo(16'd600);
    send_batch(65535, 0);
  endtask

  task automatic test_register_extremes();
    apply_settings(16'd0, 16'd1, 16'd0, 16'd0);
    send_batch(300, 0);
    send_echo(16'd300);
    send_echo(16'd301);
    send_batch(300, 0);
    apply_settings(16'hFFFF, 16'd0, 16'hFFFF, 16'd0);
    send_batch(1, 65534);
    send_batch(1, 0);
    apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0);
    send_batch(65535, 0);
    send_batch(1, 3000);
    apply_settings(16'hFFFF, 16'd1, 16'hFFFF, 16'hFFFF);
    send_batch(65535, 0);
    send_batch(40000, 20);
    // near floor above the safe distance
    apply_settings(16'd100, 16'd10, 16'd20, 16'd50);
    send_batch(300, 50);
    send_batch(100, 20);
    apply_settings(16'd50, 16'd58, 16'd20, 16'd5);
    send_batch(580, 0);
    send_batch(1, 0);
  endtask

  task automatic test_hold_off();
    tx_steady = 1'b1;
    rx_steady = 1'b0;
    send_batch(2000, 40);
    send_echo(16'd900);
    drain_results();
    send_echo(16'd950);
    send_batch(1500, 60);
    tx_steady = 1'b0;
  endtask

  task automatic randomize_settings();
    logic [RegW-1:0] lim, dv, safe, flr;
    case ($urandom_range(0, 3))
      0: lim = 16'd0;
      1: lim = 16'hFFFF;
      default: lim = 16'($urandom_range(1, 400));
    endcase
    case ($urandom_range(0, 7))
      0: dv = 16'd0;
      1: dv = 16'd1;
      2: dv = 16'hFFFF;
      default: dv = 16'($urandom_range(2, 300));
    endcase
    safe = ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom_range(0, 1200));
    flr  = ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom_range(0, 600));
    apply_settings(lim, dv, safe, flr);
  endtask

  task automatic test_random();
    int          start;
    int unsigned base, width;
    start = items_sent;
    while (items_sent - start < RandomItems) begin
      if ($urandom_range(0, 4) == 0) tx_steady = ($urandom_range(0, 2) == 0);
      if ($urandom_range(0, 4) == 0) rx_steady = ($urandom_range(0, 2) == 0);
      case ($urandom_range(0, 1)) 
        0: base = $urandom_range(1, 3000);
        default: base = $urandom_range(1, 65535);
      endcase
      width = $urandom_range(0, lim_cfg + lim_cfg / 4 + 4);
      case ($urandom_range(0, 11))
        0, 1, 2, 3, 4, 5, 6: send_batch(base, width);
        7: begin
          repeat ($urandom_range(1, 5)) send_echo(16'($urandom_range(1, 65535)));
          send_echo(16'd0);
        end
        8, 9: begin
          repeat ($urandom_range(1, 4))
            send_echo(($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom));
        end
        10: drain_results();
        default: randomize_settings();
      endcase
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = RegSpreadLimit;
    cfg_wdata_i   = '0;
    lim_cfg       = SpreadLimitRst;
    div_cfg       = TickDivisorRst;
    safe_cfg      = SafeDistanceRst;
    floor_cfg     = NearFloorRst;
    batch_fill    = '0;
    tick_sum      = '0;
    peak_hi       = '0;
    peak_lo       = '0;
    primed        = 1'b0;
    mismatches    = 0;
    items_sent    = 0;
    idle_cycles   = 0;
    rx_wait       = 0;
    tx_steady     = 1'b0;
    rx_steady     = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    test_reset_defaults();
    test_register_extremes();
    test_hold_off();
    test_random();
    drain_results();

    if (pending_readings.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("echo_trimmed_mean_ranger regression: pass");
    end else begin
      $display("echo_trimmed_mean_ranger regression: fail");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/etmr_pkg.sv
src/etmr_accum.sv
src/etmr_div.sv
src/echo_trimmed_mean_ranger.sv
tb/sv/tb_echo_trimmed_mean_ranger.sv
